### src/ffb_pkg.sv
// shared types, constants and register codes for the wheel encoder force block
// no dependencies
package ffb_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_DEADZONE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_FORCE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POSITION_MIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POSITION_MAX    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ENDSTOP_FORCE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ENDSTOP_WIDTH   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FORCE_LIMIT     = 3'd6;
    localparam int CFG_DATA_W = 24;

    // field widths
    localparam int HOST_W  = 16;
    localparam int AXIS_W  = 24;
    localparam int FORCE_W = 16;
    localparam int MAG_W   = 15;
    localparam int DZ_W    = 16;
    localparam int PMIN_W  = 24;
    localparam int PMAX_W  = 23;
    localparam int POS_W   = 32;

    // endstop arithmetic
    localparam int DIST_W    = 32;
    localparam int PROD_W    = DIST_W + MAG_W;
    localparam int DEN_W     = 16;
    localparam int DIV_STEPS = PROD_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int PUSH_W    = 17;
    localparam int SUM_W     = 19;
    localparam int BASE_W    = HOST_W + 1;

    // floor(x / 10) for 15-bit x as (x * TENTH_MUL) >> TENTH_SHIFT
    localparam int TENTH_MUL   = 52429;
    localparam int TENTH_SHIFT = 19;
    localparam int TENTH_PW    = MAG_W + 16;
    localparam int TENTH_W     = TENTH_PW - TENTH_SHIFT;

    typedef struct packed {
        logic [DZ_W-1:0]          center_deadzone;
        logic [MAG_W-1:0]         center_force;
        logic signed [PMIN_W-1:0] position_min;
        logic [PMAX_W-1:0]        position_max;
        logic [MAG_W-1:0]         endstop_force;
        logic [DEN_W-1:0]         endstop_width;
        logic [MAG_W-1:0]         force_limit;
    } cfg_t;

    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MUL,
        ST_START,
        ST_DIV,
        ST_FIN,
        ST_OUT
    } state_t;

endpackage

### src/ffb_in_if.sv
// input request channel of the wheel encoder force block
// depends on ffb_pkg
interface ffb_in_if;
    logic                               valid;
    logic                               ready;
    logic                               mode;
    logic                               phase_a;
    logic                               phase_b;
    logic signed [ffb_pkg::HOST_W-1:0]  host_force;

    modport source (output valid, output mode, output phase_a, output phase_b,
                    output host_force, input ready);
    modport sink (input valid, input mode, input phase_a, input phase_b,
                  input host_force, output ready);
endinterface

### src/ffb_out_if.sv
// result channel of the wheel encoder force block
// depends on ffb_pkg
interface ffb_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [ffb_pkg::AXIS_W-1:0]   axis_position;
    logic signed [ffb_pkg::FORCE_W-1:0]  drive_force;

    modport source (output valid, output axis_position, output drive_force,
                    input ready);
    modport sink (input valid, input axis_position, input drive_force,
                  output ready);
endinterface

### src/ffb_cfg_if.sv
// configuration write channel of the wheel encoder force block
// depends on ffb_pkg
interface ffb_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [ffb_pkg::CFG_IDX_W-1:0]     index;
    logic [ffb_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### src/wheel_encoder_force_feedback.sv
// wheel encoder position tracker with force feedback and endstop springs
// steps: an encoder request goes straight to the output; a force request is evaluated,
// and past a limit is also multiplied and run through the serial endstop divider
// throughput: one request at a time, the next taken the cycle after the result loads
// reset: asynchronous active low, position and phase b cleared, registers at defaults
// depends on ffb_pkg, the channel interfaces, ffb_regs and ffb_div
module wheel_encoder_force_feedback (
    input  logic      clk,
    input  logic      rst_n,
    ffb_in_if.sink    item,
    ffb_out_if.source result,
    ffb_cfg_if.sink   cfg
);

    ffb_pkg::cfg_t      regs;
    ffb_pkg::state_t    state_reg, state_next;
    ffb_pkg::div_ctrl_t div_ctrl;
    ffb_pkg::div_stat_t div_stat;
    logic [ffb_pkg::PROD_W-1:0] div_quo;

    // wheel state
    logic [ffb_pkg::POS_W-1:0] position_reg;
    logic                      prev_b_reg;

    // per request working registers
    logic                                mode_reg;
    logic signed [ffb_pkg::HOST_W-1:0]   host_reg;
    logic [ffb_pkg::DIST_W-1:0]          dist_reg;
    logic                                upper_reg, lower_reg;
    logic signed [ffb_pkg::BASE_W-1:0]   base_reg;
    logic [ffb_pkg::TENTH_W-1:0]         tenth_reg;
    logic [ffb_pkg::PROD_W-1:0]          prod_reg;
    logic signed [ffb_pkg::FORCE_W-1:0]  force_reg;

    // result register
    logic                                out_valid_reg;
    logic signed [ffb_pkg::AXIS_W-1:0]   axis_reg;
    logic signed [ffb_pkg::FORCE_W-1:0]  drive_reg;

    logic accept;
    logic load_out;
    logic out_free;

    ffb_regs u_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    ffb_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (prod_reg),
        .divisor  (regs.endstop_width),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    // signed views of position and limits
    logic signed [ffb_pkg::POS_W-1:0] pos_s;
    logic signed [ffb_pkg::POS_W-1:0] pmin_s;
    logic signed [ffb_pkg::POS_W-1:0] pmax_s;
    logic signed [ffb_pkg::POS_W-1:0] dz_s;
    logic                             upper_c, lower_c;

    assign pos_s   = $signed(position_reg);
    assign pmin_s  = ffb_pkg::POS_W'(regs.position_min);
    assign pmax_s  = $signed({{(ffb_pkg::POS_W-ffb_pkg::PMAX_W){1'b0}}, regs.position_max});
    assign dz_s    = $signed({{(ffb_pkg::POS_W-ffb_pkg::DZ_W){1'b0}}, regs.center_deadzone});
    // upper endstop wins when the limits are crossed
    assign upper_c = pos_s > pmax_s;
    assign lower_c = !upper_c && (pos_s < pmin_s);

    // endstop distance, always fits 32 bits unsigned
    logic [ffb_pkg::POS_W:0] dist_c;
    assign dist_c = upper_c ? ({pos_s[ffb_pkg::POS_W-1], pos_s} - {pmax_s[ffb_pkg::POS_W-1], pmax_s})
                            : ({pmin_s[ffb_pkg::POS_W-1], pmin_s} - {pos_s[ffb_pkg::POS_W-1], pos_s});

    // host force negated, else self-centering outside the deadzone
    logic signed [ffb_pkg::BASE_W-1:0] base_c;
    logic signed [ffb_pkg::BASE_W-1:0] cf_s;
    assign cf_s = $signed({{(ffb_pkg::BASE_W-ffb_pkg::MAG_W){1'b0}}, regs.center_force});
    always_comb
    begin
        if (host_reg != '0)
            base_c = -$signed({host_reg[ffb_pkg::HOST_W-1], host_reg});
        else if (pos_s > dz_s)
            base_c = -cf_s;
        else if (pos_s < -dz_s)
            base_c = cf_s;
        else
            base_c = '0;
    end

    // endstop floor is a tenth of the endstop force setting
    logic [ffb_pkg::TENTH_PW-1:0] tenth_prod;
    assign tenth_prod = ffb_pkg::TENTH_PW'(regs.endstop_force)
                      * ffb_pkg::TENTH_PW'(ffb_pkg::TENTH_MUL);

    // push saturates; anything past the saturation point is clamped anyway
    logic [ffb_pkg::PUSH_W-1:0]        push_c;
    logic [ffb_pkg::PUSH_W-1:0]        quo_sat;
    logic [ffb_pkg::PUSH_W-1:0]        tenth_ext;
    logic signed [ffb_pkg::SUM_W-1:0]  sum_c;
    logic signed [ffb_pkg::SUM_W-1:0]  lim_s;
    logic signed [ffb_pkg::FORCE_W-1:0] clamp_c;

    assign tenth_ext = ffb_pkg::PUSH_W'(tenth_reg);
    assign quo_sat   = (div_quo[ffb_pkg::PROD_W-1:ffb_pkg::PUSH_W-1] != '0)
                     ? {1'b0, {(ffb_pkg::PUSH_W-1){1'b1}}}
                     : div_quo[ffb_pkg::PUSH_W-1:0];
    assign push_c    = (quo_sat < tenth_ext) ? tenth_ext : quo_sat;
    assign lim_s     = $signed({{(ffb_pkg::SUM_W-ffb_pkg::MAG_W){1'b0}}, regs.force_limit});

    always_comb
    begin
        sum_c = ffb_pkg::SUM_W'(base_reg);
        if (upper_reg)
            sum_c = sum_c + $signed({2'b00, push_c});
        else if (lower_reg)
            sum_c = sum_c - $signed({2'b00, push_c});
        if (sum_c > lim_s)
            clamp_c = lim_s[ffb_pkg::FORCE_W-1:0];
        else if (sum_c < -lim_s)
            clamp_c = ffb_pkg::FORCE_W'(-lim_s);
        else
            clamp_c = sum_c[ffb_pkg::FORCE_W-1:0];
    end

    // reported position clamp, lower limit tested first
    logic signed [ffb_pkg::AXIS_W-1:0] axis_c;
    always_comb
    begin
        if (pos_s < pmin_s)
            axis_c = regs.position_min;
        else if (pos_s > pmax_s)
            axis_c = $signed({1'b0, regs.position_max});
        else
            axis_c = pos_s[ffb_pkg::AXIS_W-1:0];
    end

    assign out_free = !out_valid_reg || result.ready;

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ffb_pkg::ST_IDLE:
                if (accept)
                    state_next = item.mode ? ffb_pkg::ST_EVAL : ffb_pkg::ST_OUT;
            ffb_pkg::ST_EVAL:
                state_next = (upper_c || lower_c) ? ffb_pkg::ST_MUL : ffb_pkg::ST_FIN;
            ffb_pkg::ST_MUL:
                state_next = ffb_pkg::ST_START;
            ffb_pkg::ST_START:
                state_next = ffb_pkg::ST_DIV;
            ffb_pkg::ST_DIV:
                if (div_stat.done)
                    state_next = ffb_pkg::ST_FIN;
            ffb_pkg::ST_FIN:
                state_next = ffb_pkg::ST_OUT;
            ffb_pkg::ST_OUT:
                if (out_free)
                    state_next = ffb_pkg::ST_IDLE;
            default:
                state_next = ffb_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        item.ready     = 1'b0;
        div_ctrl.start = 1'b0;
        load_out       = 1'b0;
        unique case (state_reg)
            ffb_pkg::ST_IDLE:  item.ready     = 1'b1;
            ffb_pkg::ST_START: div_ctrl.start = 1'b1;
            ffb_pkg::ST_OUT:   load_out       = out_free;
            default:           item.ready     = 1'b0;
        endcase
    end

    assign accept = item.valid && item.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ffb_pkg::ST_IDLE;
            position_reg  <= '0;
            prev_b_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // encoder edge: step up when a differs from the old b
            if (accept && !item.mode)
            begin
                position_reg <= position_reg + ((item.phase_a != prev_b_reg)
                                                ? ffb_pkg::POS_W'(1) : '1);
                prev_b_reg   <= item.phase_b;
            end
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // working datapath, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg  <= item.mode;
            host_reg  <= item.host_force;
            force_reg <= '0;
        end
        if (state_reg == ffb_pkg::ST_EVAL)
        begin
            dist_reg  <= dist_c[ffb_pkg::DIST_W-1:0];
            upper_reg <= upper_c;
            lower_reg <= lower_c;
            base_reg  <= base_c;
            tenth_reg <= tenth_prod[ffb_pkg::TENTH_PW-1:ffb_pkg::TENTH_SHIFT];
        end
        if (state_reg == ffb_pkg::ST_MUL)
            prod_reg <= ffb_pkg::PROD_W'(dist_reg) * ffb_pkg::PROD_W'(regs.endstop_force);
        if (state_reg == ffb_pkg::ST_FIN)
            force_reg <= clamp_c;
        if (load_out)
        begin
            axis_reg  <= axis_c;
            drive_reg <= force_reg;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.axis_position = axis_reg;
    assign result.drive_force   = drive_reg;

`ifndef SYNTHESIS
    a_load_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ffb_pkg::ST_OUT))
        else $error("result raised outside the output step");
    a_pos_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ffb_pkg::ST_IDLE) |=> $stable(position_reg))
        else $error("position moved while a request was in work");
    a_encoder_no_force: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && !mode_reg) |-> (force_reg == '0))
        else $error("encoder request carries a force");
    a_div_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> (state_reg == ffb_pkg::ST_DIV))
        else $error("divider running outside the divide step");
`endif

endmodule

### src/ffb_regs.sv
// configuration register file with reset values
// depends on ffb_pkg and ffb_cfg_if
module ffb_regs (
    input  logic          clk,
    input  logic          rst_n,
    ffb_cfg_if.sink       cfg,
    output ffb_pkg::cfg_t regs
);

    ffb_pkg::cfg_t regs_reg;
    ffb_pkg::cfg_t regs_next;
    logic          wr;

    assign cfg.ready = 1'b1;
    assign wr        = cfg.valid && cfg.ready;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (wr)
        begin
            unique case (cfg.index)
                ffb_pkg::REG_CENTER_DEADZONE:
                    regs_next.center_deadzone = cfg.data[ffb_pkg::DZ_W-1:0];
                ffb_pkg::REG_CENTER_FORCE:
                    regs_next.center_force = cfg.data[ffb_pkg::MAG_W-1:0];
                ffb_pkg::REG_POSITION_MIN:
                    regs_next.position_min = $signed(cfg.data[ffb_pkg::PMIN_W-1:0]);
                ffb_pkg::REG_POSITION_MAX:
                    regs_next.position_max = cfg.data[ffb_pkg::PMAX_W-1:0];
                ffb_pkg::REG_ENDSTOP_FORCE:
                    regs_next.endstop_force = cfg.data[ffb_pkg::MAG_W-1:0];
                ffb_pkg::REG_ENDSTOP_WIDTH:
                    regs_next.endstop_width = cfg.data[ffb_pkg::DEN_W-1:0];
                ffb_pkg::REG_FORCE_LIMIT:
                    regs_next.force_limit = cfg.data[ffb_pkg::MAG_W-1:0];
                default:
                    regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.center_deadzone <= 16'd10;
            regs_reg.center_force    <= 15'd1000;
            regs_reg.position_min    <= -24'sd1000;
            regs_reg.position_max    <= 23'd1000;
            regs_reg.endstop_force   <= 15'd10000;
            regs_reg.endstop_width   <= 16'd100;
            regs_reg.force_limit     <= 15'd32767;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

### src/ffb_div.sv
// restoring divider, one quotient bit per cycle
// depends on ffb_pkg
module ffb_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ffb_pkg::div_ctrl_t           ctrl,
    input  logic [ffb_pkg::PROD_W-1:0]   dividend,
    input  logic [ffb_pkg::DEN_W-1:0]    divisor,
    output ffb_pkg::div_stat_t           stat,
    output logic [ffb_pkg::PROD_W-1:0]   quotient
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [ffb_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic [ffb_pkg::PROD_W-1:0]    quo_reg, quo_next;
    logic [ffb_pkg::DEN_W-1:0]     rem_reg, rem_next;
    logic [ffb_pkg::DEN_W-1:0]     den_reg, den_next;
    logic [ffb_pkg::DEN_W+1:0]     trial;

    // shift in the next dividend bit and try the subtract
    assign trial = {1'b0, rem_reg, quo_reg[ffb_pkg::PROD_W-1]} - {2'b00, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (ctrl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = ffb_pkg::CNT_W'(ffb_pkg::DIV_STEPS - 1);
            quo_next  = dividend;
            rem_next  = '0;
            // zero width behaves as width one
            den_next  = (divisor == '0) ? ffb_pkg::DEN_W'(1) : divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[ffb_pkg::DEN_W+1])
            begin
                rem_next = trial[ffb_pkg::DEN_W-1:0];
                quo_next = {quo_reg[ffb_pkg::PROD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[ffb_pkg::DEN_W-2:0], quo_reg[ffb_pkg::PROD_W-1]};
                quo_next = {quo_reg[ffb_pkg::PROD_W-2:0], 1'b0};
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - ffb_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

`ifndef SYNTHESIS
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.start |-> !busy_reg)
        else $error("divider started while busy");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg) && !busy_reg)
        else $error("divider done without a finished run");
    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (rem_reg < den_reg))
        else $error("divider remainder not below divisor");
`endif

endmodule

### bench/wheel_encoder_force_feedback_tb.sv
// self-checking bench for wheel_encoder_force_feedback: encoder steps, force requests,
// endstop springs and register settings, checked against an in-bench predictor
// depends on ffb_pkg, ffb_in_if, ffb_out_if, ffb_cfg_if and the block under test
module wheel_encoder_force_feedback_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic MODE_EDGE  = 1'b0;
    localparam logic MODE_FORCE = 1'b1;

    // cycles left for the block to settle once the last reading is in
    localparam int SETTLE_CYCLES = 64;
    // long receiver hold-off that fills the block and backs up its input
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int PHASES = 12;
    localparam int BURST_ITEMS = 125;

    typedef struct packed {
        logic                               mode;
        logic                               phase_a;
        logic                               phase_b;
        logic signed [ffb_pkg::HOST_W-1:0]  host_force;
    } wheel_req_t;

    typedef struct packed {
        logic signed [ffb_pkg::AXIS_W-1:0]  axis_position;
        logic signed [ffb_pkg::FORCE_W-1:0] drive_force;
    } wheel_reading_t;

    logic clk;
    logic rst_n;

    ffb_in_if  item_ch ();
    ffb_out_if result_ch ();
    ffb_cfg_if cfg_ch ();

    wheel_encoder_force_feedback uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // predictor copy of the registers and the wheel state
    ffb_pkg::cfg_t             model_cfg;
    logic [ffb_pkg::POS_W-1:0] wheel_pos;
    logic                      last_b;

    // requests waiting to be offered, readings waiting to come back
    wheel_req_t     wheel_requests[$];
    wheel_reading_t expected_readings[$];

    // sender side
    wheel_req_t offered_req;
    bit         offering;
    bit         req_taken;
    int         gap_left;
    int         tx_stretch;
    bit         tx_idle;

    // receiver side
    bit reading_taken;
    int stall_left;
    int rx_stretch;
    bit rx_idle;
    int hold_off_left;

    // encoder levels of the last queued edge, used to build gray-code walks
    logic enc_a;
    logic enc_b;

    wheel_reading_t due;
    int mismatch_count;
    int readings_checked;
    int requests_queued;
    int endstop_hits;
    int settings_loaded;

    // spring force for a given overtravel, never below a tenth of the endstop force
    function automatic longint spring_push(input longint span);
        longint w;
        longint p;
        longint floor_p;
        // zero width behaves as one tick
        w = (model_cfg.endstop_width == '0) ? 1 : longint'(model_cfg.endstop_width);
        p = span * longint'(model_cfg.endstop_force) / w;
        floor_p = longint'(model_cfg.endstop_force) / 10;
        return (p < floor_p) ? floor_p : p;
    endfunction

    // advance the wheel state by one request and work out its reading
    function automatic wheel_reading_t predict_wheel(input wheel_req_t r);
        longint pos;
        longint shown;
        longint drive;
        longint lo;
        longint hi;
        longint dz;
        longint fl;
        wheel_reading_t res;
        if (r.mode == MODE_EDGE)
        begin
            // a against the previous b gives the direction, 32-bit wrap
            if (r.phase_a != last_b)
                wheel_pos = wheel_pos + ffb_pkg::POS_W'(1);
            else
                wheel_pos = wheel_pos - ffb_pkg::POS_W'(1);
            last_b = r.phase_b;
        end
        pos = longint'($signed(wheel_pos));
        lo = longint'($signed(model_cfg.position_min));
        hi = longint'(model_cfg.position_max);
        // crossed limits: the lower one wins for the report
        shown = pos;
        if (shown < lo)
            shown = lo;
        else if (shown > hi)
            shown = hi;
        drive = 0;
        if (r.mode == MODE_FORCE)
        begin
            dz = longint'(model_cfg.center_deadzone);
            if (r.host_force != '0)
                drive = -longint'(r.host_force);
            else if (pos > dz)
                drive = -longint'(model_cfg.center_force);
            else if (pos < -dz)
                drive = longint'(model_cfg.center_force);
            if (pos > hi)
            begin
                drive = drive + spring_push(pos - hi);
                endstop_hits++;
            end
            else if (pos < lo)
            begin
                drive = drive - spring_push(lo - pos);
                endstop_hits++;
            end
            fl = longint'(model_cfg.force_limit);
            if (drive > fl)
                drive = fl;
            if (drive < -fl)
                drive = -fl;
        end
        res.axis_position = shown[ffb_pkg::AXIS_W-1:0];
        res.drive_force = drive[ffb_pkg::FORCE_W-1:0];
        return res;
    endfunction

    // clock and known levels on every input from time zero
    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.mode = MODE_EDGE;
        item_ch.phase_a = 1'b0;
        item_ch.phase_b = 1'b0;
        item_ch.host_force = '0;
        result_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = ffb_pkg::REG_CENTER_DEADZONE;
        cfg_ch.data = '0;
        forever #5 clk = ~clk;
    end

    // request acceptance: predict the reading at the edge the block takes the request
    always @(posedge clk)
    begin
        if (rst_n && item_ch.valid && item_ch.ready)
        begin
            expected_readings.push_back(predict_wheel(offered_req));
            req_taken = 1'b1;
        end
    end

    // request driver: one request at a time, random gaps in stretches
    always @(negedge clk)
    begin
        if (req_taken)
        begin
            req_taken = 1'b0;
            offering = 1'b0;
            if (tx_stretch == 0)
            begin
                tx_stretch = $urandom_range(10, 60);
                tx_idle = ($urandom_range(0, 3) != 0);
            end
            tx_stretch--;
            gap_left = tx_idle ? $urandom_range(0, 8) : 0;
        end
        if (!offering)
        begin
            if (gap_left > 0)
                gap_left--;
            else if (wheel_requests.size() > 0)
            begin
                offered_req = wheel_requests.pop_front();
                offering = 1'b1;
            end
        end
        item_ch.valid <= offering;
        item_ch.mode <= offered_req.mode;
        item_ch.phase_a <= offered_req.phase_a;
        item_ch.phase_b <= offered_req.phase_b;
        item_ch.host_force <= offered_req.host_force;
    end

    // reading monitor: compare with the oldest expectation, field by field
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            reading_taken = 1'b1;
            if (expected_readings.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected reading: axis %0d drive %0d",
                             result_ch.axis_position, result_ch.drive_force);
            end
            else
            begin
                due = expected_readings.pop_front();
                if (result_ch.axis_position !== due.axis_position ||
                    result_ch.drive_force !== due.drive_force)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("reading %0d: expected axis %0d drive %0d, got axis %0d drive %0d",
                                 readings_checked, due.axis_position, due.drive_force,
                                 result_ch.axis_position, result_ch.drive_force);
                end
                readings_checked++;
            end
        end
    end

    // long hold-off counter, loaded by the stimulus
    always @(posedge clk)
    begin
        if (hold_off_left > 0)
            hold_off_left <= hold_off_left - 1;
    end

    // receiver ready: random stalls per reading, in stretches, plus the hold-off
    always @(negedge clk)
    begin
        if (reading_taken)
        begin
            reading_taken = 1'b0;
            if (rx_stretch == 0)
            begin
                rx_stretch = $urandom_range(10, 60);
                rx_idle = ($urandom_range(0, 3) != 0);
            end
            rx_stretch--;
            stall_left = rx_idle ? $urandom_range(0, 8) : 0;
        end
        if (hold_off_left > 0)
            result_ch.ready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            result_ch.ready <= 1'b0;
        end
        else
            result_ch.ready <= 1'b1;
    end

    // register write over the config channel, mirrored into the predictor
    task automatic write_reg(input logic [ffb_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ffb_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        do
            @(posedge clk);
        while (!(cfg_ch.valid && cfg_ch.ready));
        case (idx)
            ffb_pkg::REG_CENTER_DEADZONE:
                model_cfg.center_deadzone = val[ffb_pkg::DZ_W-1:0];
            ffb_pkg::REG_CENTER_FORCE:
                model_cfg.center_force = val[ffb_pkg::MAG_W-1:0];
            ffb_pkg::REG_POSITION_MIN:
                model_cfg.position_min = val[ffb_pkg::PMIN_W-1:0];
            ffb_pkg::REG_POSITION_MAX:
                model_cfg.position_max = val[ffb_pkg::PMAX_W-1:0];
            ffb_pkg::REG_ENDSTOP_FORCE:
                model_cfg.endstop_force = val[ffb_pkg::MAG_W-1:0];
            ffb_pkg::REG_ENDSTOP_WIDTH:
                model_cfg.endstop_width = val[ffb_pkg::DEN_W-1:0];
            ffb_pkg::REG_FORCE_LIMIT:
                model_cfg.force_limit = val[ffb_pkg::MAG_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic load_settings(input int dz, input int cf, input int pmin, input int pmax,
                                 input int ef, input int ew, input int fl);
        write_reg(ffb_pkg::REG_CENTER_DEADZONE, ffb_pkg::CFG_DATA_W'(dz));
        write_reg(ffb_pkg::REG_CENTER_FORCE, ffb_pkg::CFG_DATA_W'(cf));
        write_reg(ffb_pkg::REG_POSITION_MIN, ffb_pkg::CFG_DATA_W'(pmin));
        write_reg(ffb_pkg::REG_POSITION_MAX, ffb_pkg::CFG_DATA_W'(pmax));
        write_reg(ffb_pkg::REG_ENDSTOP_FORCE, ffb_pkg::CFG_DATA_W'(ef));
        write_reg(ffb_pkg::REG_ENDSTOP_WIDTH, ffb_pkg::CFG_DATA_W'(ew));
        write_reg(ffb_pkg::REG_FORCE_LIMIT, ffb_pkg::CFG_DATA_W'(fl));
        settings_loaded++;
    endtask

    task automatic queue_req(input logic mode, input logic a, input logic b,
                             input logic signed [ffb_pkg::HOST_W-1:0] host);
        wheel_req_t r;
        r.mode = mode;
        r.phase_a = a;
        r.phase_b = b;
        r.host_force = host;
        wheel_requests.push_back(r);
        if (mode == MODE_EDGE)
        begin
            enc_a = a;
            enc_b = b;
        end
        requests_queued++;
    endtask

    task automatic force_req(input logic signed [ffb_pkg::HOST_W-1:0] host);
        queue_req(MODE_FORCE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), host);
    endtask

    // gray-code walk: every step moves the wheel one tick the chosen way
    task automatic spin(input int steps, input bit up);
        logic a;
        logic b;
        for (int k = 0; k < steps; k++)
        begin
            a = enc_a;
            b = enc_b;
            if (up)
            begin
                if (a == b)
                    a = !a;
                else
                    b = !b;
            end
            else
            begin
                if (a == b)
                    b = !b;
                else
                    a = !a;
            end
            queue_req(MODE_EDGE, a, b, ffb_pkg::HOST_W'($urandom));
        end
    endtask

    // mostly well-formed walks with a slow drift so the endstops get hit,
    // mixed with force requests and some random edges
    task automatic random_burst(input int count);
        int made;
        int pick;
        int run;
        bit drift_up;
        logic signed [ffb_pkg::HOST_W-1:0] host;
        made = 0;
        drift_up = 1'($urandom_range(0, 1));
        while (made < count)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 5)
            begin
                run = $urandom_range(1, 12);
                spin(run, ($urandom_range(0, 3) != 0) ? drift_up : !drift_up);
                made += run;
            end
            else if (pick < 8)
            begin
                // zero host force often, so self-centering gets exercised
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: host = '0;
                    4, 5, 6:    host = ffb_pkg::HOST_W'($urandom_range(0, 600) - 300);
                    default:    host = ffb_pkg::HOST_W'($urandom);
                endcase
                force_req(host);
                made++;
            end
            else
            begin
                // random levels, either mode
                queue_req(pick[0], 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          ffb_pkg::HOST_W'($urandom));
                made++;
            end
            if ($urandom_range(0, 29) == 0)
                drift_up = !drift_up;
        end
    endtask

    // sender pause: nothing left to offer and every reading back
    task automatic wait_idle();
        while (wheel_requests.size() != 0 || offering || expected_readings.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int dz;
        int cf;
        int pmin;
        int pmax;
        int ef;
        int ew;
        int fl;

        // reset values of the registers and the wheel
        model_cfg.center_deadzone = ffb_pkg::DZ_W'(10);
        model_cfg.center_force = ffb_pkg::MAG_W'(1000);
        model_cfg.position_min = ffb_pkg::PMIN_W'(-1000);
        model_cfg.position_max = ffb_pkg::PMAX_W'(1000);
        model_cfg.endstop_force = ffb_pkg::MAG_W'(10000);
        model_cfg.endstop_width = ffb_pkg::DEN_W'(100);
        model_cfg.force_limit = ffb_pkg::MAG_W'(32767);
        wheel_pos = '0;
        last_b = 1'b0;
        enc_a = 1'b0;
        enc_b = 1'b0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // register defaults: centered wheel, host force extremes,
        // most negative host force negates past the clamp
        force_req(16'h0000);
        force_req(16'h8000);
        force_req(16'h7fff);
        force_req(16'h0001);
        wait_idle();

        // tight limits, no deadzone, zero endstop width
        load_settings(0, 32767, -2, 2, 32767, 0, 32767);
        queue_req(MODE_EDGE, 1'b0, 1'b0, 16'h0000);
        force_req(16'h0000);
        queue_req(MODE_EDGE, 1'b1, 1'b1, 16'hffff);
        force_req(16'h0000);
        spin(3, 1'b1);
        force_req(16'h0000);
        force_req(16'hffff);
        spin(6, 1'b0);
        force_req(16'h0000);
        force_req(16'h7fff);
        wait_idle();

        // crossed limits: lower limit above the upper one
        write_reg(ffb_pkg::REG_POSITION_MIN, ffb_pkg::CFG_DATA_W'(4));
        write_reg(ffb_pkg::REG_POSITION_MAX, ffb_pkg::CFG_DATA_W'(0));
        force_req(16'h0000);
        spin(5, 1'b1);
        force_req(16'h0000);
        force_req(16'h0123);
        wait_idle();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: load_settings(3, 500, -20, 20, 4000, 10, 32767);
                1: load_settings(65535, 32767, -8388608, 8388607, 32767, 65535, 32767);
                2: load_settings(0, 0, 0, 0, 0, 1, 0);
                3: load_settings(10, 1000, -1000, 1000, 10000, 100, 32767);
                default:
                begin
                    dz = $urandom_range(0, 40);
                    if ($urandom_range(0, 7) == 0)
                        dz = $urandom_range(0, 65535);
                    cf = $urandom_range(0, 32767);
                    pmin = 0 - int'($urandom_range(0, 60));
                    pmax = $urandom_range(0, 60);
                    if ($urandom_range(0, 3) == 0)
                    begin
                        pmin = 0 - int'($urandom_range(0, 8388608));
                        pmax = $urandom_range(0, 8388607);
                    end
                    else if ($urandom_range(0, 5) == 0)
                    begin
                        pmin = $urandom_range(1, 30);
                        pmax = $urandom_range(0, pmin - 1);
                    end
                    ef = $urandom_range(0, 32767);
                    case ($urandom_range(0, 9))
                        0:       ew = 0;
                        1:       ew = $urandom_range(1, 65535);
                        default: ew = $urandom_range(1, 300);
                    endcase
                    fl = ($urandom_range(0, 4) == 0) ? 32767 : $urandom_range(0, 32767);
                    load_settings(dz, cf, pmin, pmax, ef, ew, fl);
                end
            endcase
            if (ph == 0)
            begin
                // receiver goes away while requests keep coming
                @(negedge clk);
                hold_off_left = HOLD_OFF_CYCLES;
                random_burst(40);
                wait_idle();
            end
            random_burst(BURST_ITEMS);
            wait_idle();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("checked %0d readings from %0d requests over %0d register settings",
                 readings_checked, requests_queued, settings_loaded);
        $display("%0d force requests past a travel limit, %0d mismatches",
                 endstop_hits, mismatch_count);
        if (expected_readings.size() != 0)
            $display("%0d readings never arrived", expected_readings.size());
        if (mismatch_count == 0 && expected_readings.size() == 0)
            $display("wheel_encoder_force_feedback test passed");
        else
            $display("wheel_encoder_force_feedback test failed");
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial
    begin
        #5ms;
        $display("timeout waiting for readings");
        $display("wheel_encoder_force_feedback test failed");
        $finish;
    end

endmodule
